FILE: design/ordered_list_insert_remove_find_unit_defines.svh
// assertion macros for the ordered list unit
`ifndef ORDERED_LIST_INSERT_REMOVE_FIND_UNIT_DEFINES_SVH
`define ORDERED_LIST_INSERT_REMOVE_FIND_UNIT_DEFINES_SVH

// same-cycle implication
`define OLIF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("olif assertion failed");

// next-cycle implication
`define OLIF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("olif assertion failed");

`endif

FILE: design/olif_pkg.sv
package olif_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;
    localparam int OCC_W     = 5;

    typedef enum logic [1:0] {
        FUNC_APPEND  = 2'd0,
        FUNC_PREPEND = 2'd1,
        FUNC_REMOVE  = 2'd2,
        FUNC_FIND    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic              compare;
        logic              apply;
        t_func             func;
        logic              room;
        logic [VAL_W-1:0]  key;
    } t_cell_ctl;

endpackage

FILE: design/ordered_list_insert_remove_find_unit.sv
// Ordered list of up to DEPTH 32-bit values held in a row of cells, head in cell 0.
// A request is handled in order: it is registered at acceptance, every cell then
// compares its value with the request value and registers the match, and in the
// APPLY state the first match ripples down the row while each cell loads its new
// value from the request, its left neighbor or its right neighbor. The result sits
// in an output register, so the next request is accepted while it waits to be
// taken; the update of a request holds while the previous result is still stalled.
module ordered_list_insert_remove_find_unit #(
    parameter int DEPTH = olif_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_func,
    input  logic signed [olif_pkg::VAL_W-1:0]  i_item_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_hit,
    output logic                               o_rejected,
    output logic [olif_pkg::OCC_W-1:0]         o_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    olif_pkg::t_state           r_state;
    olif_pkg::t_state           n_state;
    olif_pkg::t_func            r_func;
    logic [olif_pkg::VAL_W-1:0] r_key;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic                       r_hit;
    logic                       n_hit;
    logic                       r_rejected;
    logic                       n_rejected;

    logic                       accept;
    logic                       done;
    logic                       full;
    logic                       is_insert;
    olif_pkg::t_cell_ctl        cell_ctl;
    logic [olif_pkg::VAL_W-1:0] w_value [DEPTH];
    logic                       w_seen  [DEPTH];

    assign accept    = i_in_valid && (r_state == olif_pkg::ST_IDLE);
    assign done      = (r_state == olif_pkg::ST_APPLY) && (!r_out_valid || !i_out_stall);
    assign full      = (r_count == CW'(DEPTH));
    assign is_insert = (r_func == olif_pkg::FUNC_APPEND) || (r_func == olif_pkg::FUNC_PREPEND);

    assign cell_ctl.compare = (r_state == olif_pkg::ST_CMP);
    assign cell_ctl.apply   = done;
    assign cell_ctl.func    = r_func;
    assign cell_ctl.room    = !full;
    assign cell_ctl.key     = r_key;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [olif_pkg::VAL_W-1:0] prev_value;
            logic [olif_pkg::VAL_W-1:0] next_value;
            logic                       prev_seen;

            if (gi == 0) begin : g_head
                assign prev_value = r_key;
                assign prev_seen  = 1'b0;
            end else begin : g_mid
                assign prev_value = w_value[gi-1];
                assign prev_seen  = w_seen[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign next_value = w_value[gi];
            end else begin : g_body
                assign next_value = w_value[gi+1];
            end

            olif_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl),
                .i_live       (CW'(gi) < r_count),
                .i_tail       (CW'(gi) == r_count),
                .i_prev_value (prev_value),
                .i_next_value (next_value),
                .i_prev_seen  (prev_seen),
                .o_value      (w_value[gi]),
                .o_seen       (w_seen[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_hit       = r_hit;
        n_rejected  = r_rejected;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            olif_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = olif_pkg::ST_CMP;
                end
            end
            olif_pkg::ST_CMP: begin
                n_state = olif_pkg::ST_APPLY;
            end
            olif_pkg::ST_APPLY: begin
                if (done) begin
                    n_state     = olif_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                    n_rejected  = is_insert && full;
                    n_hit       = !is_insert && w_seen[DEPTH-1];
                    if (is_insert && !full) begin
                        n_count = r_count + CW'(1);
                    end else if ((r_func == olif_pkg::FUNC_REMOVE) && w_seen[DEPTH-1]) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
                n_state = olif_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= olif_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= olif_pkg::t_func'(i_func);
            r_key  <= i_item_value;
        end
        r_hit      <= n_hit;
        r_rejected <= n_rejected;
    end

    assign o_in_stall  = (r_state != olif_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_rejected  = r_rejected;
    assign o_occupancy = olif_pkg::OCC_W'(r_count);

endmodule

FILE: design/olif_cell.sv
module olif_cell (
    input  logic                        i_clk,
    input  olif_pkg::t_cell_ctl         i_ctl,
    input  logic                        i_live,
    input  logic                        i_tail,
    input  logic [olif_pkg::VAL_W-1:0]  i_prev_value,
    input  logic [olif_pkg::VAL_W-1:0]  i_next_value,
    input  logic                        i_prev_seen,
    output logic [olif_pkg::VAL_W-1:0]  o_value,
    output logic                        o_seen
);

    logic [olif_pkg::VAL_W-1:0] r_value;
    logic [olif_pkg::VAL_W-1:0] n_value;
    logic                       r_match;
    logic                       n_match;

    // first match from the head ripples toward the tail
    assign o_seen  = i_prev_seen | r_match;
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        n_match = r_match;
        if (i_ctl.compare) begin
            n_match = i_live && (r_value == i_ctl.key);
        end
        if (i_ctl.apply) begin
            case (i_ctl.func)
                olif_pkg::FUNC_APPEND: begin
                    if (i_ctl.room && i_tail) begin
                        n_value = i_ctl.key;
                    end
                end
                olif_pkg::FUNC_PREPEND: begin
                    if (i_ctl.room) begin
                        n_value = i_prev_value;
                    end
                end
                olif_pkg::FUNC_REMOVE: begin
                    if (o_seen) begin
                        n_value = i_next_value;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_match <= n_match;
    end

endmodule

FILE: design/olif_checker.sv
`include "ordered_list_insert_remove_find_unit_defines.svh"

module olif_checker #(
    parameter int DEPTH = olif_pkg::DEPTH_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_hit,
    input logic                               o_rejected,
    input logic [olif_pkg::OCC_W-1:0]         o_occupancy
);

    // a request keeps the unit busy for the next cycle
    `OLIF_ASSERT_NEXT(a_busy_after_request, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // an insert is refused only on a full list
    `OLIF_ASSERT_IMPL(a_reject_when_full, i_clk, i_rst_n, o_out_valid && o_rejected, o_occupancy == olif_pkg::OCC_W'(DEPTH))

    // a result never both hits and rejects
    `OLIF_ASSERT_IMPL(a_hit_or_reject, i_clk, i_rst_n, o_out_valid, !(o_hit && o_rejected))

    // a stalled result holds
    `OLIF_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_hit) && $stable(o_rejected) && $stable(o_occupancy))

endmodule

bind ordered_list_insert_remove_find_unit olif_checker #(.DEPTH(DEPTH)) u_olif_checker (.*);

FILE: tb/olif_list_tracker.sv
`timescale 1ns / 1ps

module olif_list_tracker #(
    parameter int DEPTH = olif_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [1:0]                   i_func,
    input  logic [olif_pkg::VAL_W-1:0]   i_item_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic                         i_hit,
    input  logic                         i_rejected,
    input  logic [olif_pkg::OCC_W-1:0]   i_occupancy,
    output int                           o_fail_count,
    output int                           o_pending
);

    typedef struct packed {
        logic                        hit;
        logic                        rejected;
        logic [olif_pkg::OCC_W-1:0]  occupancy;
    } t_list_result;

    logic [olif_pkg::VAL_W-1:0] held [DEPTH];
    int                         held_count;
    t_list_result               expected_q [$];

    // updates the held list and returns what the block should report
    function automatic t_list_result apply_request(olif_pkg::t_func op,
                                                   logic [olif_pkg::VAL_W-1:0] v);
        t_list_result r;
        int pos;
        r = '0;
        pos = -1;
        for (int i = 0; i < held_count; i++) begin
            if (pos < 0 && held[i] == v) begin
                pos = i;
            end
        end
        case (op)
            olif_pkg::FUNC_APPEND: begin
                if (held_count >= DEPTH) begin
                    r.rejected = 1'b1;
                end else begin
                    held[held_count] = v;
                    held_count++;
                end
            end
            olif_pkg::FUNC_PREPEND: begin
                if (held_count >= DEPTH) begin
                    r.rejected = 1'b1;
                end else begin
                    for (int i = held_count; i > 0; i--) begin
                        held[i] = held[i-1];
                    end
                    held[0] = v;
                    held_count++;
                end
            end
            olif_pkg::FUNC_REMOVE: begin
                if (pos >= 0) begin
                    for (int i = pos; i + 1 < held_count; i++) begin
                        held[i] = held[i+1];
                    end
                    held_count--;
                    r.hit = 1'b1;
                end
            end
            default: begin
                r.hit = (pos >= 0);
            end
        endcase
        r.occupancy = held_count[olif_pkg::OCC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int want_v, int got_v);
        $display("%0t: %s mismatch, expected %0d got %0d", $realtime, what, want_v, got_v);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            held_count = 0;
            expected_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_q.push_back(apply_request(olif_pkg::t_func'(i_func), i_item_value));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected request result", 0, 1);
                end else begin
                    want = expected_q.pop_front();
                    if (i_hit !== want.hit) begin
                        report_mismatch("hit", want.hit, i_hit);
                    end
                    if (i_rejected !== want.rejected) begin
                        report_mismatch("rejected", want.rejected, i_rejected);
                    end
                    if (i_occupancy !== want.occupancy) begin
                        report_mismatch("occupancy", want.occupancy, i_occupancy);
                    end
                end
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int LONG_HOLD_CYCLES = 60;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [1:0]                    in_func;
    logic [olif_pkg::VAL_W-1:0]    in_value;
    logic                          out_valid;
    logic                          out_stall;
    logic                          hit;
    logic                          rejected;
    logic [olif_pkg::OCC_W-1:0]    occupancy;
    int                            fail_count;
    int                            pending;

    int                            send_idle_pct;
    int                            recv_idle_pct;
    logic                          long_hold_req;
    logic [olif_pkg::VAL_W-1:0]    recent_vals [$];

    ordered_list_insert_remove_find_unit uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_func       (in_func),
        .i_item_value (in_value),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_hit        (hit),
        .o_rejected   (rejected),
        .o_occupancy  (occupancy)
    );

    olif_list_tracker u_tracker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_func       (in_func),
        .i_item_value (in_value),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_hit        (hit),
        .i_rejected   (rejected),
        .i_occupancy  (occupancy),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("ordered_list_insert_remove_find_unit test failed");
        $finish;
    end

    // receiver side, with a single long hold-off when long_hold_req is set
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // entered right after a rising edge, returns at the edge that takes the request
    task automatic send_request(olif_pkg::t_func f, logic [olif_pkg::VAL_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_func  <= f;
        in_value <= v;
        do @(posedge clk); while (in_stall);
        if (f == olif_pkg::FUNC_APPEND || f == olif_pkg::FUNC_PREPEND) begin
            recent_vals.push_back(v);
            if (recent_vals.size() > 24) begin
                void'(recent_vals.pop_front());
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // mode 0 favors inserts, mode 1 favors removes, mode 2 is even
    task automatic pick_request(int mode, output olif_pkg::t_func f,
                                output logic [olif_pkg::VAL_W-1:0] v);
        int r;
        int k;
        r = $urandom_range(99);
        case (mode)
            0:       f = (r < 40) ? olif_pkg::FUNC_APPEND : (r < 75) ? olif_pkg::FUNC_PREPEND :
                         (r < 85) ? olif_pkg::FUNC_REMOVE : olif_pkg::FUNC_FIND;
            1:       f = (r < 10) ? olif_pkg::FUNC_APPEND : (r < 20) ? olif_pkg::FUNC_PREPEND :
                         (r < 75) ? olif_pkg::FUNC_REMOVE : olif_pkg::FUNC_FIND;
            default: f = olif_pkg::t_func'(r[1:0]);
        endcase
        k = $urandom_range(99);
        if (k < 30) begin
            case ($urandom_range(7))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7fff_ffff;
                2:       v = 32'hffff_ffff;
                3:       v = 32'h0000_0000;
                default: v = olif_pkg::VAL_W'($urandom_range(9));
            endcase
        end else if (k < 70 && recent_vals.size() > 0) begin
            v = recent_vals[$urandom_range(recent_vals.size() - 1)];
        end else begin
            v = $urandom;
        end
    endtask

    task automatic run_random(int count);
        olif_pkg::t_func            f;
        logic [olif_pkg::VAL_W-1:0] v;
        int                         mode;
        int                         burst;
        burst = 0;
        mode  = 2;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                mode  = $urandom_range(2);
                burst = $urandom_range(30, 8);
            end
            burst--;
            pick_request(mode, f, v);
            send_request(f, v);
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_func       = olif_pkg::FUNC_APPEND;
        in_value      = '0;
        long_hold_req = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 49;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, extremes, duplicates, misses
        send_request(olif_pkg::FUNC_FIND, 32'h0000_0000);
        send_request(olif_pkg::FUNC_REMOVE, 32'h0000_0000);
        send_request(olif_pkg::FUNC_APPEND, 32'h8000_0000);
        send_request(olif_pkg::FUNC_PREPEND, 32'h7fff_ffff);
        send_request(olif_pkg::FUNC_APPEND, 32'h0000_0000);
        send_request(olif_pkg::FUNC_APPEND, 32'hffff_ffff);
        send_request(olif_pkg::FUNC_PREPEND, 32'd5);
        send_request(olif_pkg::FUNC_APPEND, 32'd5);
        send_request(olif_pkg::FUNC_FIND, 32'd5);
        send_request(olif_pkg::FUNC_REMOVE, 32'd5);
        send_request(olif_pkg::FUNC_FIND, 32'd5);
        send_request(olif_pkg::FUNC_REMOVE, 32'd123);
        // fill up, then inserts into a full list
        for (int i = 0; i < 11; i++) begin
            send_request(i[0] ? olif_pkg::FUNC_PREPEND : olif_pkg::FUNC_APPEND,
                         olif_pkg::VAL_W'(i * 1000 - 5000));
        end
        send_request(olif_pkg::FUNC_APPEND, 32'h1234_5678);
        send_request(olif_pkg::FUNC_PREPEND, 32'h8765_4321);

        run_random(220);
        wait_drained();

        send_idle_pct = 49;
        recv_idle_pct = 37;
        run_random(220);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_req = 1'b1;
        run_random(210);
        wait_drained();

        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ordered_list_insert_remove_find_unit test passed");
        end else begin
            $display("ordered_list_insert_remove_find_unit test failed");
        end
        $finish;
    end

endmodule
